// File: src/clock_synced_step_ramp_macros.svh
// Assertion helpers used by the checker file.
`ifndef CLOCK_SYNCED_STEP_RAMP_MACROS_SVH
`define CLOCK_SYNCED_STEP_RAMP_MACROS_SVH

// Same-cycle implication, off during reset.
`define CSSR_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cssr assertion failed");

// Next-cycle implication, off during reset.
`define CSSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cssr assertion failed");

// Holds while reset is applied.
`define CSSR_ASSERT_RST(label, clk, rst_n, cons) \
	label: assert property (@(posedge clk) !(rst_n) |-> (cons)) \
		else $error("cssr reset assertion failed");

`endif

// File: src/cssr_pkg.sv
package cssr_pkg;

	localparam int COUNT_BITS  = 24;
	localparam int MAX_LENGTH  = 32;
	localparam int LEVEL_BITS  = 16;

	localparam int BEAT_W      = $clog2(MAX_LENGTH);
	localparam int LEN_W       = 6;
	localparam int SUB_W       = 6;
	localparam int GLIDE_W     = 9;
	localparam int SUB_LIMIT   = 32;
	localparam int GLIDE_FULL  = 256;
	localparam int LOCAL_W     = $clog2(SUB_LIMIT);
	localparam int STEP_W      = $clog2(MAX_LENGTH * SUB_LIMIT + 1);

	// fixed-point layout of the in-step fraction
	localparam int GLIDE_SHIFT = 16;
	localparam int FRAC_BITS   = 24;
	localparam int LV_W        = STEP_W + FRAC_BITS;
	localparam int LV_SHIFT    = FRAC_BITS - LEVEL_BITS;

	// shared divider sizing
	localparam int DVD_W       = GLIDE_W + COUNT_BITS + GLIDE_SHIFT;
	localparam int DVR_W       = COUNT_BITS;
	localparam int CNT_W       = $clog2(DVD_W + 1);

	// configuration port
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = COUNT_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBDIV_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GLIDE_AMOUNT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TIMEOUT = 2'd3;

	localparam logic [LEN_W-1:0]      LEN_RESET     = 6'd8;
	localparam logic [SUB_W-1:0]      SUB_RESET     = 6'd4;
	localparam logic [GLIDE_W-1:0]    GLIDE_RESET   = 9'd0;
	localparam logic [COUNT_BITS-1:0] TIMEOUT_RESET = COUNT_BITS'(480000);

	// effective (clamped) configuration
	typedef struct packed {
		logic [LEN_W-1:0]      len;
		logic [SUB_W-1:0]      sub;
		logic [GLIDE_W-1:0]    glide;
		logic [COUNT_BITS-1:0] timeout;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] nbits;
		logic [DVD_W-1:0] dividend;
		logic [DVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quot;
		logic [DVR_W-1:0] rem;
	} div_rsp_t;

endpackage

// File: src/cssr_if.sv
interface cssr_in_if;
	logic valid;
	logic ready;
	logic clock_high;

	modport source (output valid, output clock_high, input ready);
	modport sink   (input valid, input clock_high, output ready);
endinterface

interface cssr_out_if;
	logic                            valid;
	logic                            ready;
	logic [cssr_pkg::LEVEL_BITS-1:0] step_value;
	logic                            subdivision_pulse;
	logic [cssr_pkg::BEAT_W-1:0]     beat_index;

	modport source (output valid, output step_value, output subdivision_pulse,
		output beat_index, input ready);
	modport sink   (input valid, input step_value, input subdivision_pulse,
		input beat_index, output ready);
endinterface

// File: src/cssr_div.sv
// Restoring divider, one quotient bit per cycle.
// Caller left-aligns the dividend so its nbits live at the top.
module cssr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  cssr_pkg::div_req_t req,
	output cssr_pkg::div_rsp_t rsp
);
	import cssr_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVR_W-1:0] rem_q;
	logic [DVR_W-1:0] dvr_q;

	logic [DVR_W:0]   trial;
	logic [DVR_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvr_q};
	assign fits  = trial >= {1'b0, dvr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvr_q <= req.divisor;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// File: src/cssr_cfg.sv
// Configuration registers and range clamping.
module cssr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [cssr_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [cssr_pkg::CFG_DATA_W-1:0] wr_data,
	output cssr_pkg::cfg_t                 cfg
);
	import cssr_pkg::*;

	logic [LEN_W-1:0]      len_q;
	logic [SUB_W-1:0]      sub_q;
	logic [GLIDE_W-1:0]    glide_q;
	logic [COUNT_BITS-1:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= LEN_RESET;
			sub_q     <= SUB_RESET;
			glide_q   <= GLIDE_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_SEQ_LENGTH:     len_q     <= wr_data[LEN_W-1:0];
				REG_SUBDIV_COUNT:   sub_q     <= wr_data[SUB_W-1:0];
				REG_GLIDE_AMOUNT:   glide_q   <= wr_data[GLIDE_W-1:0];
				REG_PERIOD_TIMEOUT: timeout_q <= wr_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (len_q == '0)
			cfg.len = LEN_W'(1);
		else if (len_q > LEN_W'(MAX_LENGTH))
			cfg.len = LEN_W'(MAX_LENGTH);
		else
			cfg.len = len_q;
		cfg.sub     = (sub_q > SUB_W'(SUB_LIMIT)) ? SUB_W'(SUB_LIMIT) : sub_q;
		cfg.glide   = (glide_q > GLIDE_W'(GLIDE_FULL)) ? GLIDE_W'(GLIDE_FULL) : glide_q;
		cfg.timeout = timeout_q;
	end

endmodule

// File: src/cssr_ctrl.sv
// Per-tick sequencer: edge detect, beat advance on a rising edge, then, unless the level
// holds, a chain of divisions on the shared divider to build the stepped level.
module cssr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  cssr_pkg::cfg_t     cfg,
	cssr_in_if.sink            ticks,
	cssr_out_if.source         levels,
	output cssr_pkg::div_req_t div_req,
	input  cssr_pkg::div_rsp_t div_rsp
);
	import cssr_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MOD   = 4'd1;
	localparam logic [3:0] ST_CHECK = 4'd2;
	localparam logic [3:0] ST_SLEN  = 4'd3;
	localparam logic [3:0] ST_LOC   = 4'd4;
	localparam logic [3:0] ST_MUL   = 4'd5;
	localparam logic [3:0] ST_ELAP  = 4'd6;
	localparam logic [3:0] ST_GLIDE = 4'd7;
	localparam logic [3:0] ST_FRAC  = 4'd8;
	localparam logic [3:0] ST_LV    = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;

	localparam int PROD_W  = LOCAL_W + COUNT_BITS;
	localparam int GPROD_W = GLIDE_W + COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [3:0]            state_q;
	logic                  prev_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] period_q;
	logic [BEAT_W-1:0]     beat_q;
	logic [LEVEL_BITS-1:0] held_q;

	logic [COUNT_BITS-1:0] step_len_q;
	logic [LOCAL_W-1:0]    local_q;
	logic [PROD_W-1:0]     prod_q;
	logic [STEP_W-1:0]     step_q;
	logic [STEP_W-1:0]     total_q;
	logic [COUNT_BITS-1:0] elapsed_q;
	logic [LEVEL_BITS-1:0] lvl_q;
	logic                  pls_q;

	logic                  out_valid_q;
	logic [LEVEL_BITS-1:0] out_level_q;
	logic                  out_pulse_q;
	logic [BEAT_W-1:0]     out_beat_q;

	logic                  accept;
	logic                  rise;
	logic                  hold;
	logic                  out_free;
	logic [BEAT_W:0]       beat_inc;
	logic [LOCAL_W-1:0]    sub_m1;
	logic [LOCAL_W-1:0]    local_c;
	logic [STEP_W-1:0]     total_c;
	logic [STEP_W-1:0]     step_raw;
	logic [COUNT_BITS-1:0] diff_c;
	logic [GPROD_W-1:0]    gprod_c;
	logic [LV_W-1:0]       lv_num;
	logic [LEVEL_BITS-1:0] lv_sat;

	assign ticks.ready = (state_q == ST_IDLE);
	assign accept      = ticks.valid & ticks.ready;
	assign rise        = ticks.clock_high & ~prev_q;
	assign out_free    = ~out_valid_q | levels.ready;

	assign hold     = (cfg.sub == '0) || (period_q <= COUNT_BITS'(cfg.sub));
	assign beat_inc = (BEAT_W+1)'(beat_q) + (BEAT_W+1)'(1);
	assign sub_m1   = LOCAL_W'(cfg.sub - SUB_W'(1));
	assign local_c  = (div_rsp.quot > DVD_W'(sub_m1)) ? sub_m1 : div_rsp.quot[LOCAL_W-1:0];
	assign total_c  = STEP_W'(cfg.len) * STEP_W'(cfg.sub);
	assign step_raw = STEP_W'(beat_q) * STEP_W'(cfg.sub) + STEP_W'(local_q);
	// prod never exceeds the count, so the low bits suffice
	assign diff_c   = count_q - prod_q[COUNT_BITS-1:0];
	assign gprod_c  = GPROD_W'(cfg.glide) * GPROD_W'(elapsed_q);
	assign lv_num   = {step_q, {FRAC_BITS{1'b0}}} + LV_W'(div_rsp.quot[FRAC_BITS:0]);
	assign lv_sat   = (|div_rsp.quot[DVD_W-1:LEVEL_BITS]) ? {LEVEL_BITS{1'b1}}
		: div_rsp.quot[LEVEL_BITS-1:0];

	// divider requests, issued in the cycle the sequencer moves on
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && rise) begin
					div_req.start    = 1'b1;
					div_req.nbits    = CNT_W'(BEAT_W + 1);
					div_req.dividend = {beat_inc, {(DVD_W-BEAT_W-1){1'b0}}};
					div_req.divisor  = DVR_W'(cfg.len);
				end
			end
			ST_CHECK: begin
				if (!hold) begin
					div_req.start    = 1'b1;
					div_req.nbits    = CNT_W'(COUNT_BITS);
					div_req.dividend = {period_q, {(DVD_W-COUNT_BITS){1'b0}}};
					div_req.divisor  = DVR_W'(cfg.sub);
				end
			end
			ST_SLEN: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.nbits    = CNT_W'(COUNT_BITS);
					div_req.dividend = {count_q, {(DVD_W-COUNT_BITS){1'b0}}};
					div_req.divisor  = div_rsp.quot[DVR_W-1:0];
				end
			end
			ST_GLIDE: begin
				div_req.start    = 1'b1;
				div_req.nbits    = CNT_W'(DVD_W);
				div_req.dividend = {gprod_c, {GLIDE_SHIFT{1'b0}}};
				div_req.divisor  = step_len_q;
			end
			ST_FRAC: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.nbits    = CNT_W'(LV_W);
					div_req.dividend = {lv_num, {(DVD_W-LV_W){1'b0}}};
					div_req.divisor  = DVR_W'({total_q, {LV_SHIFT{1'b0}}});
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= 1'b0;
			count_q     <= '0;
			period_q    <= '0;
			beat_q      <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (levels.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_q <= ticks.clock_high;
						if (rise) begin
							if (count_q < cfg.timeout)
								period_q <= count_q;
							count_q <= '0;
							state_q <= ST_MOD;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_MOD: begin
					if (div_rsp.done) begin
						beat_q  <= div_rsp.rem[BEAT_W-1:0];
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: state_q <= hold ? ST_FIN : ST_SLEN;
				ST_SLEN:  if (div_rsp.done) state_q <= ST_LOC;
				ST_LOC:   if (div_rsp.done) state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_ELAP;
				ST_ELAP:  state_q <= ST_GLIDE;
				ST_GLIDE: state_q <= ST_FRAC;
				ST_FRAC:  if (div_rsp.done) state_q <= ST_LV;
				ST_LV: begin
					if (div_rsp.done) begin
						held_q  <= lv_sat;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						if (count_q != COUNT_MAX)
							count_q <= count_q + COUNT_BITS'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_CHECK: begin
				if (hold) begin
					lvl_q <= held_q;
					pls_q <= 1'b0;
				end
			end
			ST_SLEN: if (div_rsp.done) step_len_q <= div_rsp.quot[COUNT_BITS-1:0];
			ST_LOC: begin
				if (div_rsp.done) begin
					local_q <= local_c;
					pls_q   <= (count_q < period_q) && (div_rsp.rem == '0);
				end
			end
			ST_MUL: begin
				prod_q  <= PROD_W'(local_q) * PROD_W'(step_len_q);
				total_q <= total_c;
				step_q  <= (step_raw > total_c - STEP_W'(1)) ? total_c - STEP_W'(1) : step_raw;
			end
			ST_ELAP: elapsed_q <= (diff_c > step_len_q) ? step_len_q : diff_c;
			ST_LV:   if (div_rsp.done) lvl_q <= lv_sat;
			ST_FIN: begin
				if (out_free) begin
					out_level_q <= lvl_q;
					out_pulse_q <= pls_q;
					out_beat_q  <= beat_q;
				end
			end
			default: ;
		endcase
	end

	assign levels.valid             = out_valid_q;
	assign levels.step_value        = out_level_q;
	assign levels.subdivision_pulse = out_pulse_q;
	assign levels.beat_index        = out_beat_q;

endmodule

// File: src/clock_synced_step_ramp.sv
// Clock-synced stepped ramp: one result transaction per tick transaction.
// Each tick runs a 6-bit beat modulo on a rising clock edge; an active tick then runs
//   divisions of 24, 24, 49 and 35 bits before its result registers.
// Throughput: the next tick is taken in the cycle after the result registers, and an
//   output stall holds it off further.
// Reset (arst_n low, async): state clears; length 8, 4 subdivisions, no glide, timeout 480000.
module clock_synced_step_ramp (
	input  logic                            clk,
	input  logic                            arst_n,
	cssr_in_if.sink                         ticks,
	cssr_out_if.source                      levels,
	input  logic                            wr_en,
	input  logic [cssr_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [cssr_pkg::CFG_DATA_W-1:0] wr_data
);
	import cssr_pkg::*;

	// clamped register view: length 1..32, subdivisions 0..32, glide 0..256
	cfg_t     cfg;

	// shared divider handshake: beat modulo, step length, local step,
	// glide fraction and final level scaling all run through it in turn
	div_req_t div_req;
	div_rsp_t div_rsp;

	cssr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// one quotient bit per cycle; dividend widths 6, 24, 24, 49 and 35 bits
	cssr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer: takes a tick only when idle, and holds the finished result
	// in an output register so the next tick can start while it waits
	cssr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.ticks   (ticks),
		.levels  (levels),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

endmodule

// File: src/cssr_checker.sv
`include "clock_synced_step_ramp_macros.svh"

// Port-level checks on the ramp block.
module cssr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [cssr_pkg::LEVEL_BITS-1:0] out_level,
	input logic                            out_pulse,
	input logic [cssr_pkg::BEAT_W-1:0]     out_beat
);

	// stalled result holds
	`CSSR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_level) && $stable(out_pulse) && $stable(out_beat))

	// a taken tick keeps the sequencer busy through the state it enters and the one after
	`CSSR_ASSERT_NEXT(a_busy_after_tick, clk, arst_n, in_valid && in_ready, !in_ready ##1 !in_ready)

	// with no result pending, none is offered in the cycle after a tick is taken
	`CSSR_ASSERT(a_no_result_at_take, clk, arst_n, in_valid && in_ready && !out_valid, ##1 !out_valid)

	// no result during reset
	`CSSR_ASSERT_RST(a_rst_quiet, clk, arst_n, !out_valid)

endmodule

bind clock_synced_step_ramp cssr_checker u_cssr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (ticks.valid),
	.in_ready  (ticks.ready),
	.out_valid (levels.valid),
	.out_ready (levels.ready),
	.out_level (levels.step_value),
	.out_pulse (levels.subdivision_pulse),
	.out_beat  (levels.beat_index)
);

// File: tb/clock_synced_step_ramp_tb.sv
`timescale 1ns / 100ps

// Tick stream in, ramp level stream out, config through the write port.
// Every tick transaction yields exactly one level transaction.
module clock_synced_step_ramp_tb;
	import cssr_pkg::*;

	// cycles without any transaction before the run is declared hung
	localparam int WATCHDOG_LIMIT = 20000;
	// quiet cycles after the last level, longer than the slowest tick
	localparam int SETTLE_CYCLES  = 300;
	localparam int RANDOM_TICKS   = 500;
	localparam int IDLE_PCT       = 11;
	localparam int N_DIR          = 38;

	localparam logic [63:0] LEVEL_MAX = (64'd1 << LEVEL_BITS) - 64'd1;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] level;
		logic                  pulse;
		logic [BEAT_W-1:0]     beat;
	} ramp_out_t;

	typedef enum logic { ROW_TICK, ROW_WRITE } row_kind_t;

	// one directed step: either a register write or a tick; a tick may carry
	// a hand-typed level where it is obvious (right after reset)
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  lvl;
		logic                  typed;
		ramp_out_t             want;
	} dir_row_t;

	typedef enum int { SHAPE_CLEAN, SHAPE_JITTER, SHAPE_NOISE } clock_shape_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	cssr_in_if  tick_ch ();
	cssr_out_if level_ch ();

	clock_synced_step_ramp DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.ticks    (tick_ch),
		.levels   (level_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #5 clk = ~clk;

	// Predictor copy of registers and state.
	logic [LEN_W-1:0]      cfg_len;
	logic [SUB_W-1:0]      cfg_sub;
	logic [GLIDE_W-1:0]    cfg_glide;
	logic [COUNT_BITS-1:0] cfg_timeout;

	logic                  st_prev;
	logic [COUNT_BITS-1:0] st_count;
	logic [COUNT_BITS-1:0] st_period;
	logic [BEAT_W-1:0]     st_beat;
	logic [LEVEL_BITS-1:0] st_held;

	ramp_out_t   pending_levels [$];
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	bit          idle_on = 1'b1;

	// Directed table. Tick rows leave idx at REG_SEQ_LENGTH, unused there.
	dir_row_t dir_rows [N_DIR] = '{
		// after reset: the first period measured is too short to ramp, so every tick holds zero
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b1, '{16'd0, 1'b0, 5'd0}},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b1, 1'b1, '{16'd0, 1'b0, 5'd1}},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b1, 1'b1, '{16'd0, 1'b0, 5'd1}},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b1, '{16'd0, 1'b0, 5'd1}},
		// full glide, one step per beat, a steady clock
		'{ROW_WRITE, REG_GLIDE_AMOUNT,   24'd256,      1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_SUBDIV_COUNT,   24'd1,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b1, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b1, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b1, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b1, 1'b0, '0},
		// out-of-range values: length 0, glide and subdivisions over the top;
		// period 3 is then not above 32 steps, so the level holds
		'{ROW_WRITE, REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_GLIDE_AMOUNT,   24'd511,      1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_SUBDIV_COUNT,   24'd63,       1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b1, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b1, 1'b0, '0},
		// zero timeout: period stays frozen at 3, length above the maximum
		'{ROW_WRITE, REG_SUBDIV_COUNT,   24'd2,        1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_SEQ_LENGTH,     24'd63,       1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_PERIOD_TIMEOUT, 24'd0,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b1, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b0, '0},
		// widest timeout, no glide
		'{ROW_WRITE, REG_PERIOD_TIMEOUT, 24'hFFFFFF,   1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_GLIDE_AMOUNT,   24'd0,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b1, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b1, 1'b0, '0},
		// zero subdivisions: forced hold
		'{ROW_WRITE, REG_SUBDIV_COUNT,   24'd0,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b0, 1'b0, '0},
		'{ROW_TICK,  REG_SEQ_LENGTH,     24'd0,        1'b1, 1'b0, '0}
	};

	// Advance the predictor by one tick and return the level it produces.
	function automatic ramp_out_t next_ramp_output(input logic lvl);
		logic [63:0] len_e, sub_e, glide_e;
		logic [63:0] step_len, total, local_s, step, elapsed, frac, lv;
		ramp_out_t r;
		len_e   = 64'(cfg_len);
		sub_e   = 64'(cfg_sub);
		glide_e = 64'(cfg_glide);
		if (len_e == 0) len_e = 1;
		if (len_e > MAX_LENGTH) len_e = MAX_LENGTH;
		if (sub_e > SUB_LIMIT) sub_e = SUB_LIMIT;
		if (glide_e > GLIDE_FULL) glide_e = GLIDE_FULL;
		r.pulse = 1'b0;

		// rising edge: latch the period if the gap was short enough
		if (lvl && !st_prev) begin
			if (st_count < cfg_timeout) st_period = st_count;
			st_count = '0;
			st_beat  = BEAT_W'((64'(st_beat) + 64'd1) % len_e);
		end
		st_prev = lvl;

		if (sub_e == 0 || 64'(st_period) <= sub_e) begin
			r.level = st_held;
		end else begin
			step_len = 64'(st_period) / sub_e;
			total    = len_e * sub_e;
			local_s  = 64'(st_count) / step_len;
			if (local_s > sub_e - 1) local_s = sub_e - 1;
			// stale beat (length shrank) is capped at the last step
			step = 64'(st_beat) * sub_e + local_s;
			if (step > total - 1) step = total - 1;
			elapsed = 64'(st_count) - local_s * step_len;
			if (elapsed > step_len) elapsed = step_len;
			frac = (glide_e * elapsed * 64'd65536) / step_len;
			lv   = (((step << 24) + frac) << LEVEL_BITS) / (total << 24);
			if (lv > LEVEL_MAX) lv = LEVEL_MAX;
			st_held = LEVEL_BITS'(lv);
			r.level = st_held;
			r.pulse = (64'(st_count) < 64'(st_period)) && ((64'(st_count) % step_len) == 0);
		end

		if (st_count != {COUNT_BITS{1'b1}}) st_count = st_count + 1'b1;
		r.beat = st_beat;
		return r;
	endfunction

	// Drop valid and wait until every expected level has come back.
	// Always waits for a clock edge first so valid is never re-raised in the same step.
	task automatic wait_levels_drained();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_levels.size() != 0) @(posedge clk);
	endtask

	// Register write, only with the block idle. wr_en is lowered by send_tick.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		wait_levels_drained();
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		case (idx)
			REG_SEQ_LENGTH:     cfg_len     = data[LEN_W-1:0];
			REG_SUBDIV_COUNT:   cfg_sub     = data[SUB_W-1:0];
			REG_GLIDE_AMOUNT:   cfg_glide   = data[GLIDE_W-1:0];
			REG_PERIOD_TIMEOUT: cfg_timeout = data[COUNT_BITS-1:0];
			default: ;
		endcase
	endtask

	// One tick transaction. Valid stays high on return so back-to-back ticks
	// go without a bubble; random gaps lower it first.
	task automatic send_tick(input logic lvl, input logic typed, input ramp_out_t want);
		ramp_out_t predicted;
		wr_en <= 1'b0;
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid      <= 1'b1;
		tick_ch.clock_high <= lvl;
		do @(posedge clk); while (!tick_ch.ready);
		predicted = next_ramp_output(lvl);
		pending_levels.push_back(typed ? want : predicted);
	endtask

	// Sink side: random back-pressure, one assignment per edge.
	always @(posedge clk) begin
		level_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
	end

	// Compare each level transaction against the oldest expectation.
	always @(posedge clk) begin
		ramp_out_t exp_r;
		if (arst_n && level_ch.valid && level_ch.ready) begin
			if (pending_levels.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected level transaction, step_value %0d",
					$time, level_ch.step_value);
			end else begin
				exp_r = pending_levels.pop_front();
				if (level_ch.step_value !== exp_r.level) begin
					mismatches++;
					if (mismatches < 100)
						$display("%0t: step_value expected %0d actual %0d",
							$time, exp_r.level, level_ch.step_value);
				end
				if (level_ch.subdivision_pulse !== exp_r.pulse) begin
					mismatches++;
					if (mismatches < 100)
						$display("%0t: subdivision_pulse expected %0d actual %0d",
							$time, exp_r.pulse, level_ch.subdivision_pulse);
				end
				if (level_ch.beat_index !== exp_r.beat) begin
					mismatches++;
					if (mismatches < 100)
						$display("%0t: beat_index expected %0d actual %0d",
							$time, exp_r.beat, level_ch.beat_index);
				end
			end
		end
	end

	// Watchdog: any transaction on either channel resets the count.
	always @(posedge clk) begin
		if ((tick_ch.valid && tick_ch.ready) || (level_ch.valid && level_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** clock_synced_step_ramp: FAILED **");
			$finish;
		end
	end

	initial begin
		int unsigned   rand_ticks;
		int unsigned   per, hi_len, lo_len, base_hi, base_lo, pos, n_ticks, k;
		logic [CFG_DATA_W-1:0] len_v, sub_v, glide_v, tmo_v;
		clock_shape_t  shape;
		logic          lvl;

		// known values on the driven inputs from time zero; the sink's ready
		// follows from the first edge, well inside reset
		arst_n             = 1'b0;
		wr_en              = 1'b0;
		wr_index           = REG_SEQ_LENGTH;
		wr_data            = '0;
		tick_ch.valid      = 1'b0;
		tick_ch.clock_high = 1'b0;

		cfg_len     = LEN_RESET;
		cfg_sub     = SUB_RESET;
		cfg_glide   = GLIDE_RESET;
		cfg_timeout = TIMEOUT_RESET;
		st_prev     = 1'b0;
		st_count    = '0;
		st_period   = '0;
		st_beat     = '0;
		st_held     = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed walk
		for (int i = 0; i < N_DIR; i++) begin
			if (dir_rows[i].kind == ROW_WRITE)
				write_register(dir_rows[i].idx, dir_rows[i].data);
			else
				send_tick(dir_rows[i].lvl, dir_rows[i].typed, dir_rows[i].want);
		end

		// Random phases: fresh registers, then a clock waveform. Most phases
		// are a clean or jittered clock so periods get measured and the ramp
		// runs; a few are plain noise. Block state persists across phases, so
		// a shrinking length leaves a stale beat now and then.
		rand_ticks = 0;
		while (rand_ticks < RANDOM_TICKS) begin
			per     = $urandom_range(48, 2);
			base_hi = $urandom_range(per - 1, 1);
			base_lo = per - base_hi;
			hi_len  = base_hi;
			lo_len  = base_lo;
			pos     = 0;
			n_ticks = $urandom_range(60, 20);
			case ($urandom_range(19))
				0, 1:    shape = SHAPE_NOISE;
				2, 3, 4: shape = SHAPE_JITTER;
				default: shape = SHAPE_CLEAN;
			endcase

			case ($urandom_range(9))
				0:       len_v = 24'd0;
				1:       len_v = 24'd63;
				2:       len_v = 24'd1;
				3:       len_v = 24'd32;
				default: len_v = CFG_DATA_W'($urandom_range(32, 1));
			endcase
			case ($urandom_range(9))
				0:       sub_v = 24'd0;
				1:       sub_v = 24'd63;
				2:       sub_v = 24'd32;
				default: sub_v = CFG_DATA_W'($urandom_range((per - 1 < 32) ? per - 1 : 32, 1));
			endcase
			case ($urandom_range(9))
				0:       glide_v = 24'd0;
				1:       glide_v = 24'd511;
				2:       glide_v = 24'd256;
				3:       glide_v = CFG_DATA_W'($urandom_range(511, 257));
				default: glide_v = CFG_DATA_W'($urandom_range(256, 0));
			endcase
			// timeout near the period hits the accept/reject boundary
			case ($urandom_range(11))
				0:       tmo_v = 24'd0;
				1:       tmo_v = 24'd1;
				2:       tmo_v = 24'hFFFFFF;
				3, 4:    tmo_v = CFG_DATA_W'($urandom_range(per + 1, per - 1));
				5:       tmo_v = CFG_DATA_W'($urandom);
				default: tmo_v = CFG_DATA_W'($urandom_range(24'hFFFFFF, per + 2));
			endcase
			write_register(REG_SEQ_LENGTH, len_v);
			write_register(REG_SUBDIV_COUNT, sub_v);
			write_register(REG_GLIDE_AMOUNT, glide_v);
			write_register(REG_PERIOD_TIMEOUT, tmo_v);

			for (k = 0; k < n_ticks; k++) begin
				// a long stretch with no idling on either side
				idle_on = !(rand_ticks >= 150 && rand_ticks < 250);
				if (shape == SHAPE_NOISE) begin
					lvl = 1'($urandom_range(1));
				end else begin
					lvl = (pos < hi_len);
					pos++;
					if (pos >= hi_len + lo_len) begin
						pos = 0;
						if (shape == SHAPE_JITTER) begin
							hi_len = $urandom_range(base_hi + 1, (base_hi > 1) ? base_hi - 1 : 1);
							lo_len = $urandom_range(base_lo + 1, (base_lo > 1) ? base_lo - 1 : 1);
						end
					end
				end
				// occasional hold-off until the block has caught up
				if ($urandom_range(99) < 2) wait_levels_drained();
				send_tick(lvl, 1'b0, '0);
				rand_ticks++;
			end
		end

		idle_on = 1'b1;
		wait_levels_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_levels.size() == 0)
			$display("** clock_synced_step_ramp: PASSED **");
		else
			$display("** clock_synced_step_ramp: FAILED **");
		$finish;
	end

endmodule
